@@ design/alle_pkg.sv @@
// shared constants and field widths for the array linked list engine
package alle_pkg;

	// default number of slots
	localparam int CAPACITY_DEF = 16;

	// stream field widths
	localparam int ACTION_W = 1;
	localparam int POS_W    = 5;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 40;

	// request kinds
	localparam logic [ACTION_W-1:0] ACT_INSERT = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

endpackage

@@ design/array_linked_list_engine_top.sv @@
// circular linked list in a slot array with a free chain, walked by a small sequencer
// errors go from S_CHECK straight to S_OUT; an insert into an empty list goes through S_FREE; other
// requests pass S_PRED, S_WALK if a walk is needed, S_NEXT, then S_LINK or S_CUR and S_RELEASE
// s_tready is high only while the sequencer is idle and the previous result has been taken, so
// one request is handled at a time
// reset: arst_n clears the list to empty; slot links read as the initial free chain
// through a fill watermark, so no clearing pass is needed after reset
module array_linked_list_engine_top #(
	parameter int CAPACITY = alle_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// position [4:0], value [36:5], zero fill [39:37]
	input  logic [alle_pkg::S_DATA_W-1:0] s_tdata,
	// action [0]
	input  logic [alle_pkg::ACTION_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status [1:0], removed_value [33:2], count [38:34], is_empty [39]
	output logic [alle_pkg::M_DATA_W-1:0] m_tdata
);

	localparam int SW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW   = $clog2(CAPACITY + 1);
	localparam int CW   = LW;
	localparam int CMPW = (CW > alle_pkg::POS_W) ? CW : alle_pkg::POS_W;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b0000000001,
		S_CHECK   = 10'b0000000010,
		S_FREE    = 10'b0000000100,
		S_PRED    = 10'b0000001000,
		S_WALK    = 10'b0000010000,
		S_NEXT    = 10'b0000100000,
		S_LINK    = 10'b0001000000,
		S_CUR     = 10'b0010000000,
		S_RELEASE = 10'b0100000000,
		S_OUT     = 10'b1000000000
	} state_t;

	// map an out of range link to slot zero
	function automatic logic [SW-1:0] slot_ok(input logic [LW-1:0] v);
		slot_ok = (v < LW'(CAPACITY)) ? v[SW-1:0] : '0;
	endfunction

	state_t state_q;

	// list bookkeeping
	logic [SW-1:0] head_q;
	logic [LW-1:0] free_head_q;
	logic [CW-1:0] count_q;
	logic [LW-1:0] fill_q;

	// request and walk registers
	logic [alle_pkg::ACTION_W-1:0] action_q;
	logic [alle_pkg::POS_W-1:0]    pos_q;
	logic [alle_pkg::VALUE_W-1:0]  value_q;
	logic [SW-1:0]                 fslot_q;
	logic [LW-1:0]                 next_free_q;
	logic [SW-1:0]                 p_q;
	logic [SW-1:0]                 pred_q;
	logic [SW-1:0]                 cur_q;
	logic [CW-1:0]                 step_q;
	logic                          tail_q;

	// result registers
	logic [alle_pkg::STATUS_W-1:0] status_q;
	logic [alle_pkg::VALUE_W-1:0]  removed_q;

	// memories
	logic [LW-1:0]                link_mem [CAPACITY];
	logic [alle_pkg::VALUE_W-1:0] value_mem [CAPACITY];
	logic [LW-1:0]                link_rd_q;
	logic [SW-1:0]                rd_addr_q;
	logic [alle_pkg::VALUE_W-1:0] value_rd_q;

	// memory port controls
	logic                          rd_en;
	logic [SW-1:0]                 rd_addr;
	logic                          wr_en;
	logic [SW-1:0]                 wr_addr;
	logic [LW-1:0]                 wr_data;
	logic                          vwr_en;

	// derived values
	logic                          s_xfer;
	logic [LW-1:0]                 link_rd;
	logic [SW-1:0]                 nxt;
	logic [CMPW-1:0]               pos_c;
	logic [CMPW-1:0]               cnt_c;
	logic [alle_pkg::STATUS_W-1:0] err_status;
	logic                          err;
	logic                          walk_go;
	logic                          walk_done;
	logic [SW-1:0]                 pred_sel;

	assign s_tready = (state_q == S_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign m_tvalid = (state_q == S_OUT);

	assign m_tdata = {
		(count_q == '0),
		alle_pkg::COUNT_W'(count_q),
		removed_q,
		status_q
	};

	// slots at or above the fill watermark still hold their reset link
	assign link_rd = (LW'(rd_addr_q) >= fill_q) ? (LW'(rd_addr_q) + LW'(1)) : link_rd_q;
	assign nxt     = slot_ok(link_rd);
	assign pos_c   = CMPW'(pos_q);
	assign cnt_c   = CMPW'(count_q);

	// request checks
	always_comb begin
		err_status = alle_pkg::ST_OK;
		err        = 1'b0;
		if (action_q == alle_pkg::ACT_INSERT) begin
			if (count_q >= CW'(CAPACITY)) begin
				err_status = alle_pkg::ST_FULL;
				err        = 1'b1;
			end else if (pos_c > cnt_c) begin
				err_status = alle_pkg::ST_BAD_POS;
				err        = 1'b1;
			end
		end else begin
			if (count_q == '0) begin
				err_status = alle_pkg::ST_EMPTY;
				err        = 1'b1;
			end else if (pos_c >= cnt_c) begin
				err_status = alle_pkg::ST_BAD_POS;
				err        = 1'b1;
			end
		end
	end

	// walk decisions
	always_comb begin
		walk_go = (count_q > CW'(1)) && (tail_q || (pos_c > CMPW'(1)));
		if (tail_q) begin
			walk_done = (nxt == head_q) || (step_q == CW'(CAPACITY - 1));
		end else begin
			walk_done = (CMPW'(step_q) + CMPW'(2)) == pos_c;
		end
		pred_sel = (tail_q && (nxt == head_q)) ? p_q : nxt;
	end

	// memory port controls per state
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = p_q;
		wr_en   = 1'b0;
		wr_addr = pred_q;
		wr_data = LW'(fslot_q);
		vwr_en  = 1'b0;
		case (state_q)
			S_CHECK: begin
				rd_addr = slot_ok(free_head_q);
				rd_en   = !err && (action_q == alle_pkg::ACT_INSERT);
			end
			S_FREE: begin
				if (count_q == '0) begin
					wr_en   = 1'b1;
					wr_addr = fslot_q;
					wr_data = LW'(fslot_q);
					vwr_en  = 1'b1;
				end
			end
			S_PRED: begin
				rd_en   = 1'b1;
				rd_addr = head_q;
			end
			S_WALK: begin
				rd_en   = 1'b1;
				rd_addr = pred_sel;
			end
			S_NEXT: begin
				if (action_q == alle_pkg::ACT_INSERT) begin
					wr_en   = 1'b1;
					wr_addr = fslot_q;
					wr_data = LW'(nxt);
				end else begin
					rd_en   = 1'b1;
					rd_addr = nxt;
				end
			end
			S_LINK: begin
				wr_en   = 1'b1;
				wr_addr = pred_q;
				wr_data = LW'(fslot_q);
				vwr_en  = 1'b1;
			end
			S_CUR: begin
				wr_en   = 1'b1;
				wr_addr = pred_q;
				wr_data = LW'(nxt);
			end
			S_RELEASE: begin
				wr_en   = 1'b1;
				wr_addr = cur_q;
				wr_data = free_head_q;
			end
			default: begin
			end
		endcase
	end

	// link and value memories
	always_ff @(posedge clk) begin
		if (wr_en) begin
			link_mem[wr_addr] <= wr_data;
		end
		if (vwr_en) begin
			value_mem[fslot_q] <= value_q;
		end
		if (rd_en) begin
			link_rd_q  <= link_mem[rd_addr];
			value_rd_q <= value_mem[rd_addr];
			rd_addr_q  <= rd_addr;
		end
	end

	// request payload and walk datapath
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			action_q <= s_tuser;
			pos_q    <= s_tdata[alle_pkg::POS_W-1:0];
			value_q  <= s_tdata[alle_pkg::POS_W +: alle_pkg::VALUE_W];
		end
		case (state_q)
			S_CHECK: begin
				fslot_q <= slot_ok(free_head_q);
				tail_q  <= (pos_c == '0) || (pos_c == cnt_c);
			end
			S_FREE: begin
				next_free_q <= link_rd;
			end
			S_PRED: begin
				p_q    <= head_q;
				pred_q <= head_q;
				step_q <= '0;
			end
			S_WALK: begin
				p_q    <= nxt;
				pred_q <= pred_sel;
				step_q <= step_q + CW'(1);
			end
			S_NEXT: begin
				cur_q <= nxt;
			end
			default: begin
			end
		endcase
	end

	// sequencer and list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			free_head_q <= '0;
			count_q     <= '0;
			fill_q      <= '0;
			status_q    <= alle_pkg::ST_OK;
			removed_q   <= '0;
		end else begin
			// watermark grows as untouched slots are written in order
			if (wr_en && (LW'(wr_addr) == fill_q)) begin
				fill_q <= fill_q + LW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (s_xfer) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					status_q  <= err_status;
					removed_q <= '0;
					if (err) begin
						state_q <= S_OUT;
					end else if (action_q == alle_pkg::ACT_INSERT) begin
						state_q <= S_FREE;
					end else begin
						state_q <= S_PRED;
					end
				end
				S_FREE: begin
					if (count_q == '0) begin
						head_q  <= fslot_q;
						count_q <= count_q + CW'(1);
						if (count_q + CW'(1) == CW'(CAPACITY)) begin
							free_head_q <= LW'(CAPACITY);
						end else begin
							free_head_q <= link_rd;
						end
						state_q <= S_OUT;
					end else begin
						state_q <= S_PRED;
					end
				end
				S_PRED: begin
					state_q <= walk_go ? S_WALK : S_NEXT;
				end
				S_WALK: begin
					if (walk_done) begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					state_q <= (action_q == alle_pkg::ACT_INSERT) ? S_LINK : S_CUR;
				end
				S_LINK: begin
					if (pos_q == '0) begin
						head_q <= fslot_q;
					end
					count_q <= count_q + CW'(1);
					if (count_q + CW'(1) == CW'(CAPACITY)) begin
						free_head_q <= LW'(CAPACITY);
					end else begin
						free_head_q <= next_free_q;
					end
					state_q <= S_OUT;
				end
				S_CUR: begin
					removed_q <= value_rd_q;
					if (pos_q == '0) begin
						head_q <= nxt;
					end
					state_q <= S_RELEASE;
				end
				S_RELEASE: begin
					free_head_q <= LW'(cur_q);
					count_q     <= count_q - CW'(1);
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
